@@ design/mpsp_pkg.sv @@
// Shared constants, codes and record types of the multi-page shelf rectangle packer.
package mpsp_pkg;

    localparam int MAX_PAGES  = 8;
    localparam int PAGE_SIZE  = 512;
    localparam int COORD_W    = 9;
    localparam int PAGE_IDX_W = 3;
    localparam int CNT_W      = 4;
    localparam int SUM_W      = COORD_W + 2;

    localparam logic [CNT_W-1:0]   BUDGET_RESET = CNT_W'(MAX_PAGES);
    localparam logic [SUM_W-1:0]   PAGE_LIMIT   = SUM_W'(PAGE_SIZE);
    localparam logic [COORD_W-1:0] CURSOR_START = COORD_W'(1);

    typedef enum logic [1:0] {
        ST_PLACED    = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] rh;
        logic               cls;
    } t_page_rec;

    typedef struct packed {
        logic      hit;
        t_page_rec rec;
    } t_fit_res;

endpackage

@@ design/mpsp_page_store.sv @@
// Page record file: one read port and one write port over all page records.
module mpsp_page_store
    import mpsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic [PAGE_IDX_W-1:0] i_rd_idx,
    output t_page_rec             o_rd_rec,
    input  logic                  i_wr_en,
    input  logic [PAGE_IDX_W-1:0] i_wr_idx,
    input  t_page_rec             i_wr_rec
);

    t_page_rec r_pages [MAX_PAGES];

    // Payload only: an entry is written when its page opens before it is read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pages[i_wr_idx] <= i_wr_rec;
        end
    end

    assign o_rd_rec = r_pages[i_rd_idx];

endmodule

@@ design/mpsp_fit_unit.sv @@
// Shelf fit test for one page record: class match, row wrap and vertical fit.
module mpsp_fit_unit
    import mpsp_pkg::*;
(
    input  t_page_rec          i_rec,
    input  logic [COORD_W-1:0] i_width,
    input  logic [COORD_W-1:0] i_height,
    input  logic               i_cls,
    output t_fit_res           o_res
);

    logic [SUM_W-1:0] end_x;
    logic             wrap;
    logic [SUM_W-1:0] row_y;
    logic [SUM_W-1:0] end_y;

    always_comb begin
        end_x = SUM_W'(i_rec.cx) + SUM_W'(i_width) + SUM_W'(1);
        wrap  = (end_x >= PAGE_LIMIT);
        // Open a new row one pixel below the tallest item of the current one.
        row_y = wrap ? (SUM_W'(i_rec.cy) + SUM_W'(i_rec.rh) + SUM_W'(1))
                     : SUM_W'(i_rec.cy);
        end_y = row_y + SUM_W'(i_height) + SUM_W'(1);

        o_res.hit     = (i_rec.cls == i_cls) && (end_y < PAGE_LIMIT);
        o_res.rec.cx  = wrap ? CURSOR_START : i_rec.cx;
        o_res.rec.cy  = row_y[COORD_W-1:0];
        o_res.rec.rh  = wrap ? '0 : i_rec.rh;
        o_res.rec.cls = i_rec.cls;
    end

endmodule

@@ design/multi_page_shelf_rect_packer_top.sv @@
// Top level of the multi-page shelf rectangle packer: sequencer, page count and result register.
//
//  channel   direction  handshake                    word
//  -------   ---------  ---------------------------  ------------------------------------
//  in        input      i_in_valid / o_in_ready      rect_width, rect_height, nearest_class
//  out       output     o_out_valid / i_out_ready    status, page_index, pos_x, pos_y,
//                                                    opened_page
//  cfg       input      i_cfg_we (no wait)           page_budget
//
//  An oversized word goes straight to commit. Otherwise the scan reads the page records
//  newest first, one per cycle through the shared fit unit, until a page takes it; when none
//  does, the page open check runs, then commit.
//  Synchronous active-low reset empties all pages and sets the page budget to 8.
//  The input is ready only while the sequencer is idle. The result register holds a word
//  while the next one runs; commit stalls only while that register is still full.
module multi_page_shelf_rect_packer_top
    import mpsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_W-1:0]    i_rect_width,
    input  logic [COORD_W-1:0]    i_rect_height,
    input  logic                  i_nearest_class,
    // result
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [PAGE_IDX_W-1:0] o_page_index,
    output logic [COORD_W-1:0]    o_pos_x,
    output logic [COORD_W-1:0]    o_pos_y,
    output logic                  o_opened_page,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CNT_W-1:0]      i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OPEN,
        S_FINISH
    } t_state;

    t_state                r_state,       n_state;
    logic [PAGE_IDX_W-1:0] r_ptr,         n_ptr;
    logic [CNT_W-1:0]      r_pages_open,  n_pages_open;
    logic [CNT_W-1:0]      r_page_budget, n_page_budget;
    logic [COORD_W-1:0]    r_width,       n_width;
    logic [COORD_W-1:0]    r_height,      n_height;
    logic                  r_cls,         n_cls;
    t_page_rec             r_rec,         n_rec;
    logic [PAGE_IDX_W-1:0] r_page,        n_page;
    logic                  r_opened,      n_opened;
    t_status               r_status,      n_status;

    logic                  r_out_valid,   n_out_valid;
    logic [1:0]            r_o_status,    n_o_status;
    logic [PAGE_IDX_W-1:0] r_o_page,      n_o_page;
    logic [COORD_W-1:0]    r_o_x,         n_o_x;
    logic [COORD_W-1:0]    r_o_y,         n_o_y;
    logic                  r_o_opened,    n_o_opened;

    t_page_rec             rd_rec;
    t_fit_res              fit;
    logic                  wr_en;
    t_page_rec             wr_rec;
    logic                  out_free;
    logic                  oversize;
    logic [CNT_W-1:0]      budget_eff;
    logic [CNT_W-1:0]      newest;
    logic [SUM_W-1:0]      next_x;

    mpsp_page_store u_store (
        .i_clk    (i_clk),
        .i_rd_idx (r_ptr),
        .o_rd_rec (rd_rec),
        .i_wr_en  (wr_en),
        .i_wr_idx (r_page),
        .i_wr_rec (wr_rec)
    );

    mpsp_fit_unit u_fit (
        .i_rec    (rd_rec),
        .i_width  (r_width),
        .i_height (r_height),
        .i_cls    (r_cls),
        .o_res    (fit)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign budget_eff = (r_page_budget > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                            : r_page_budget;
    assign newest     = r_pages_open - CNT_W'(1);
    assign oversize   = (SUM_W'(i_rect_width)  + SUM_W'(2) >= PAGE_LIMIT) ||
                        (SUM_W'(i_rect_height) + SUM_W'(2) >= PAGE_LIMIT);
    assign next_x     = SUM_W'(r_rec.cx) + SUM_W'(r_width) + SUM_W'(1);

    // Commit the placed record: advance the row cursor, grow the row height.
    assign wr_en      = (r_state == S_FINISH) && out_free && (r_status == ST_PLACED);
    assign wr_rec.cx  = next_x[COORD_W-1:0];
    assign wr_rec.cy  = r_rec.cy;
    assign wr_rec.rh  = (r_height > r_rec.rh) ? r_height : r_rec.rh;
    assign wr_rec.cls = r_cls;

    always_comb begin
        n_state       = r_state;
        n_ptr         = r_ptr;
        n_pages_open  = r_pages_open;
        n_page_budget = i_cfg_we ? i_cfg_data : r_page_budget;
        n_width       = r_width;
        n_height      = r_height;
        n_cls         = r_cls;
        n_rec         = r_rec;
        n_page        = r_page;
        n_opened      = r_opened;
        n_status      = r_status;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_o_status    = r_o_status;
        n_o_page      = r_o_page;
        n_o_x         = r_o_x;
        n_o_y         = r_o_y;
        n_o_opened    = r_o_opened;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_width  = i_rect_width;
                    n_height = i_rect_height;
                    n_cls    = i_nearest_class;
                    n_opened = 1'b0;
                    n_ptr    = newest[PAGE_IDX_W-1:0];
                    if (oversize) begin
                        n_status = ST_TOO_LARGE;
                        n_state  = S_FINISH;
                    end else if (r_pages_open == '0) begin
                        n_state  = S_OPEN;
                    end else begin
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Visit one page record per cycle, newest first.
                if (fit.hit) begin
                    n_rec    = fit.rec;
                    n_page   = r_ptr;
                    n_status = ST_PLACED;
                    n_state  = S_FINISH;
                end else if (r_ptr == '0) begin
                    n_state  = S_OPEN;
                end else begin
                    n_ptr    = r_ptr - PAGE_IDX_W'(1);
                end
            end
            S_OPEN: begin
                if (r_pages_open >= budget_eff) begin
                    n_status = ST_EXHAUSTED;
                end else begin
                    n_status     = ST_PLACED;
                    n_page       = r_pages_open[PAGE_IDX_W-1:0];
                    n_rec.cx     = CURSOR_START;
                    n_rec.cy     = CURSOR_START;
                    n_rec.rh     = '0;
                    n_rec.cls    = r_cls;
                    n_opened     = 1'b1;
                    n_pages_open = r_pages_open + CNT_W'(1);
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the result register is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    if (r_status == ST_PLACED) begin
                        n_o_page   = r_page;
                        n_o_x      = r_rec.cx;
                        n_o_y      = r_rec.cy;
                        n_o_opened = r_opened;
                    end else begin
                        n_o_page   = '0;
                        n_o_x      = '0;
                        n_o_y      = '0;
                        n_o_opened = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pages_open  <= '0;
            r_page_budget <= BUDGET_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pages_open  <= n_pages_open;
            r_page_budget <= n_page_budget;
            r_out_valid   <= n_out_valid;
        end
        r_ptr      <= n_ptr;
        r_width    <= n_width;
        r_height   <= n_height;
        r_cls      <= n_cls;
        r_rec      <= n_rec;
        r_page     <= n_page;
        r_opened   <= n_opened;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_page   <= n_o_page;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_opened <= n_o_opened;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_page_index  = r_o_page;
    assign o_pos_x       = r_o_x;
    assign o_pos_y       = r_o_y;
    assign o_opened_page = r_o_opened;

endmodule
